[design/pqadc_pkg.sv]
// ----------------------------------------------------------------------------
// pqadc_pkg
// shared constants, field layout and types of the product-quantization
// distance scan
// ----------------------------------------------------------------------------
package pqadc_pkg;

	localparam int NUM_SUBSPACES = 16;
	localparam int NUM_CENTROIDS = 256;
	localparam int ENTRY_BITS    = 24;
	localparam int DIST_BITS     = 28;

	localparam int CODE_BITS        = 8;
	localparam int SUB_FIELD_BITS   = 4;
	localparam int CENT_FIELD_BITS  = 8;
	localparam int VALUE_FIELD_BITS = 24;
	localparam int CODES_WORD_BITS  = 64;
	localparam int CENT_ADDR_BITS   = $clog2(NUM_CENTROIDS);

	// lane slots of the adder tree, four groups of four
	localparam int LANE_SLOTS = 16;
	localparam int GROUP_SIZE = 4;
	localparam int NUM_GROUPS = LANE_SLOTS / GROUP_SIZE;
	localparam int PART_BITS  = ENTRY_BITS + 2;
	localparam int TOTAL_BITS = (ENTRY_BITS + 4 > DIST_BITS) ? ENTRY_BITS + 4 : DIST_BITS;

	// input beat layout
	localparam int SUB_LSB       = 0;
	localparam int CENT_LSB      = SUB_LSB + SUB_FIELD_BITS;
	localparam int VALUE_LSB     = CENT_LSB + CENT_FIELD_BITS;
	localparam int LO_LSB        = VALUE_LSB + VALUE_FIELD_BITS;
	localparam int HI_LSB        = LO_LSB + CODES_WORD_BITS;
	localparam int IN_FIELD_BITS = HI_LSB + CODES_WORD_BITS;
	localparam int IN_TDATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = ((DIST_BITS + 7) / 8) * 8;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_SCAN  = 1'b1
	} mode_t;

	typedef logic [ENTRY_BITS-1:0] entry_t;

	typedef struct packed {
		logic                      wr;
		logic                      rd;
		logic [CENT_ADDR_BITS-1:0] waddr;
		logic [CENT_ADDR_BITS-1:0] raddr;
		logic                      raddr_ok;
		entry_t                    wdata;
	} lane_req_t;

	typedef struct packed {
		logic adv;
		logic vld;
		logic last;
	} pipe_ctrl_t;

endpackage

[design/pqadc_lane.sv]
// ----------------------------------------------------------------------------
// pqadc_lane
// one subspace lane: its row of the distance table and a registered lookup
// ----------------------------------------------------------------------------
module pqadc_lane (
	input  logic                 clk,
	input  pqadc_pkg::lane_req_t req,
	output pqadc_pkg::entry_t    val
);

	pqadc_pkg::entry_t mem [pqadc_pkg::NUM_CENTROIDS];
	pqadc_pkg::entry_t rdata_s1;
	logic              ok_s1;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rdata_s1 <= mem[req.raddr];
			ok_s1    <= req.raddr_ok;
		end
	end

	// out-of-range code adds nothing
	assign val = ok_s1 ? rdata_s1 : '0;

endmodule

[design/pqadc_merge.sv]
// ----------------------------------------------------------------------------
// pqadc_merge
// two-stage adder tree over the lane lookups with saturation to the
// distance width
// ----------------------------------------------------------------------------
module pqadc_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pqadc_pkg::pipe_ctrl_t                ctrl,
	input  pqadc_pkg::entry_t                    lane_val [pqadc_pkg::LANE_SLOTS],
	output logic                                 vld_s3,
	output logic                                 last_s3,
	output logic [pqadc_pkg::DIST_BITS-1:0]      dist_s3
);

	localparam logic [pqadc_pkg::TOTAL_BITS-1:0] DistMax =
		pqadc_pkg::TOTAL_BITS'((64'd1 << pqadc_pkg::DIST_BITS) - 64'd1);

	logic                              vld_s2;
	logic                              last_s2;
	logic [pqadc_pkg::PART_BITS-1:0]   part_s2 [pqadc_pkg::NUM_GROUPS];
	logic [pqadc_pkg::PART_BITS-1:0]   part_d  [pqadc_pkg::NUM_GROUPS];
	logic [pqadc_pkg::TOTAL_BITS-1:0]  total_d;

	always_comb begin
		for (int g = 0; g < pqadc_pkg::NUM_GROUPS; g++) begin
			part_d[g] = '0;
			for (int k = 0; k < pqadc_pkg::GROUP_SIZE; k++) begin
				part_d[g] = part_d[g] +
					pqadc_pkg::PART_BITS'(lane_val[g * pqadc_pkg::GROUP_SIZE + k]);
			end
		end
	end

	always_comb begin
		total_d = '0;
		for (int g = 0; g < pqadc_pkg::NUM_GROUPS; g++) begin
			total_d = total_d + pqadc_pkg::TOTAL_BITS'(part_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ctrl.adv) begin
			vld_s2 <= ctrl.vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			last_s2 <= ctrl.last;
			part_s2 <= part_d;
			last_s3 <= last_s2;
			dist_s3 <= (total_d > DistMax) ? pqadc_pkg::DIST_BITS'(DistMax)
				: pqadc_pkg::DIST_BITS'(total_d);
		end
	end

endmodule

[design/pq_adc_distance_scan.sv]
// ----------------------------------------------------------------------------
// pq_adc_distance_scan
// product-quantization distance scan over a 16 x 256 distance table
// ----------------------------------------------------------------------------
// input beats arrive on s_axis; tuser is the mode. a write beat (mode 0)
// stores lut_value at row lut_subspace, column lut_centroid and gives no
// output. a scan beat (mode 1) carries 16 byte codes; each lane reads its
// own table row at its code and the sixteen entries are summed into one
// distance beat on m_axis, with tlast copied from the input tlast.
// a scan beat passes the lane memory read, the partial sums, and the final sum
// and saturation, each registered, before it is offered on m_axis.
// throughput: one beat per cycle, writes and scans alike, while m_axis does
// not stall; each lane memory has one write port and one read port.
// a write is seen by any scan accepted after it.
// reset clears the pipeline and skid valid flags only; table contents
// are undefined until written.
// when m_axis stalls the pipeline holds; one more input beat is caught in
// a skid register, then s_axis_tready drops until the stall clears.
// ----------------------------------------------------------------------------
module pq_adc_distance_scan (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// lut_subspace, lut_centroid, lut_value, codes_low, codes_high, zero pad
	input  logic [pqadc_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata,
	// mode
	input  logic                                     s_axis_tuser,
	input  logic                                     s_axis_tlast,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// distance, zero pad
	output logic [pqadc_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
	output logic                                     m_axis_tlast
);

	logic                                  skid_vld_q;
	logic [pqadc_pkg::IN_TDATA_BITS-1:0]   skid_tdata_q;
	logic                                  skid_tuser_q;
	logic                                  skid_tlast_q;

	logic                                  feed_vld;
	logic [pqadc_pkg::IN_TDATA_BITS-1:0]   feed_tdata;
	pqadc_pkg::mode_t                      feed_mode;
	logic                                  feed_last;
	logic [pqadc_pkg::SUB_FIELD_BITS-1:0]  feed_sub;
	logic [pqadc_pkg::CENT_FIELD_BITS-1:0] feed_cent;
	pqadc_pkg::entry_t                     feed_value;
	logic [2*pqadc_pkg::CODES_WORD_BITS-1:0] feed_codes;
	logic                                  cent_ok;

	logic                                  en;
	logic                                  fire_wr;
	logic                                  fire_scan;
	logic                                  vld_s1;
	logic                                  last_s1;
	logic                                  vld_s3;
	logic                                  last_s3;
	logic [pqadc_pkg::DIST_BITS-1:0]       dist_s3;

	pqadc_pkg::entry_t                     lane_val [pqadc_pkg::LANE_SLOTS];
	pqadc_pkg::pipe_ctrl_t                 ctrl;

	assign s_axis_tready = !skid_vld_q;
	assign en            = !vld_s3 || m_axis_tready;

	assign feed_vld   = skid_vld_q || s_axis_tvalid;
	assign feed_tdata = skid_vld_q ? skid_tdata_q : s_axis_tdata;
	assign feed_mode  = pqadc_pkg::mode_t'(skid_vld_q ? skid_tuser_q : s_axis_tuser);
	assign feed_last  = skid_vld_q ? skid_tlast_q : s_axis_tlast;

	assign feed_sub   = feed_tdata[pqadc_pkg::SUB_LSB +: pqadc_pkg::SUB_FIELD_BITS];
	assign feed_cent  = feed_tdata[pqadc_pkg::CENT_LSB +: pqadc_pkg::CENT_FIELD_BITS];
	assign feed_value = pqadc_pkg::ENTRY_BITS'(
		feed_tdata[pqadc_pkg::VALUE_LSB +: pqadc_pkg::VALUE_FIELD_BITS]);
	assign feed_codes = feed_tdata[pqadc_pkg::LO_LSB +: 2*pqadc_pkg::CODES_WORD_BITS];
	assign cent_ok    = {1'b0, feed_cent} <
		(pqadc_pkg::CENT_FIELD_BITS+1)'(pqadc_pkg::NUM_CENTROIDS);

	assign fire_wr    = feed_vld && en && (feed_mode == pqadc_pkg::MODE_WRITE);
	assign fire_scan  = feed_vld && en && (feed_mode == pqadc_pkg::MODE_SCAN);

	// skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (en) begin
				skid_vld_q <= 1'b0;
			end
		end else if (s_axis_tvalid && !en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && s_axis_tvalid && !en) begin
			skid_tdata_q <= s_axis_tdata;
			skid_tuser_q <= s_axis_tuser;
			skid_tlast_q <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= fire_scan;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= feed_last;
		end
	end

	for (genvar m = 0; m < pqadc_pkg::LANE_SLOTS; m++) begin : g_lane
		if (m < pqadc_pkg::NUM_SUBSPACES) begin : g_used
			logic [pqadc_pkg::CODE_BITS-1:0] code;
			pqadc_pkg::lane_req_t            req;

			assign code = feed_codes[m*pqadc_pkg::CODE_BITS +: pqadc_pkg::CODE_BITS];

			always_comb begin
				req.wr       = fire_wr && cent_ok &&
					(feed_sub == pqadc_pkg::SUB_FIELD_BITS'(m));
				req.rd       = fire_scan;
				req.waddr    = feed_cent[pqadc_pkg::CENT_ADDR_BITS-1:0];
				req.raddr    = code[pqadc_pkg::CENT_ADDR_BITS-1:0];
				req.raddr_ok = {1'b0, code} <
					(pqadc_pkg::CODE_BITS+1)'(pqadc_pkg::NUM_CENTROIDS);
				req.wdata    = feed_value;
			end

			pqadc_lane u_lane (
				.clk (clk),
				.req (req),
				.val (lane_val[m])
			);
		end else begin : g_unused
			assign lane_val[m] = '0;
		end
	end

	assign ctrl = '{adv: en, vld: vld_s1, last: last_s1};

	pqadc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.lane_val (lane_val),
		.vld_s3   (vld_s3),
		.last_s3  (last_s3),
		.dist_s3  (dist_s3)
	);

	assign m_axis_tvalid = vld_s3;
	assign m_axis_tdata  = pqadc_pkg::OUT_TDATA_BITS'(dist_s3);
	assign m_axis_tlast  = last_s3;

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(!en))
		else $error("skid filled while pipeline advancing");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_wr |=> !vld_s1)
		else $error("write beat entered the scan pipeline");

	a_scan_enters: assert property (@(posedge clk) disable iff (!arst_n)
		fire_scan |=> vld_s1)
		else $error("scan beat lost at lane lookup");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (vld_s1 == $past(vld_s1)))
		else $error("lookup stage changed during stall");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for pq_adc_distance_scan
// loads the distance table with write beats, then streams scan beats whose
// codes only touch written entries; every distance beat is checked against a
// local copy of the table, under random input bursts and output stalls
// ----------------------------------------------------------------------------
module testbench;
	import pqadc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_SLACK    = 20;
	localparam int RANDOM_BEATS   = 360;

	typedef struct packed {
		mode_t                      mode;
		logic [SUB_FIELD_BITS-1:0]  row;
		logic [CENT_FIELD_BITS-1:0] col;
		entry_t                     value;
		logic [CODES_WORD_BITS-1:0] lo;
		logic [CODES_WORD_BITS-1:0] hi;
		logic                       eol;
	} pq_beat_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		logic                 last;
	} distance_result_t;

	typedef enum logic [1:0] {
		RX_STREAM,
		RX_COIN,
		RX_STALLS
	} rx_pattern_t;

	logic                        clk            = 1'b0;
	logic                        arst_n         = 1'b0;
	logic                        s_axis_tvalid  = 1'b0;
	logic                        s_axis_tready;
	logic [IN_TDATA_BITS-1:0]    s_axis_tdata   = '0;
	logic                        s_axis_tuser   = 1'b0;
	logic                        s_axis_tlast   = 1'b0;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready  = 1'b0;
	logic [OUT_TDATA_BITS-1:0]   m_axis_tdata;
	logic                        m_axis_tlast;

	entry_t           dist_table    [NUM_SUBSPACES][NUM_CENTROIDS];
	bit               entry_written [NUM_SUBSPACES][NUM_CENTROIDS];
	distance_result_t pending_distances [$];

	int          fail_count   = 0;
	int          burst_left   = 0;
	int          idle_cycles  = 0;
	rx_pattern_t rx_pattern   = RX_STREAM;
	int          pattern_left = 0;
	int          stall_left   = 0;

	pq_adc_distance_scan dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	function automatic logic [DIST_BITS-1:0] lookup_distance(logic [CODES_WORD_BITS-1:0] lo,
			logic [CODES_WORD_BITS-1:0] hi);
		logic [63:0]          acc;
		logic [CODE_BITS-1:0] code;
		int                   m;
		acc = '0;
		for (m = 0; m < NUM_SUBSPACES; m++) begin
			code = (m < 8) ? lo[m*8 +: 8] : hi[(m-8)*8 +: 8];
			if (code < NUM_CENTROIDS)
				acc += 64'(dist_table[m][code]);
		end
		if (acc > 64'((1 << DIST_BITS) - 1))
			acc = 64'((1 << DIST_BITS) - 1);
		return acc[DIST_BITS-1:0];
	endfunction

	task automatic record_beat(pq_beat_t b);
		distance_result_t r;
		if (b.mode == MODE_WRITE) begin
			if (b.row < NUM_SUBSPACES && b.col < NUM_CENTROIDS) begin
				dist_table[b.row][b.col]    = b.value;
				entry_written[b.row][b.col] = 1'b1;
			end
		end else begin
			r.distance = lookup_distance(b.lo, b.hi);
			r.last     = b.eol;
			pending_distances.push_back(r);
		end
	endtask

	function automatic pq_beat_t make_write(int row, int col, entry_t value);
		pq_beat_t b;
		b.mode  = MODE_WRITE;
		b.row   = row[SUB_FIELD_BITS-1:0];
		b.col   = col[CENT_FIELD_BITS-1:0];
		b.value = value;
		b.lo    = {$urandom, $urandom};
		b.hi    = {$urandom, $urandom};
		b.eol   = $urandom_range(0, 1);
		return b;
	endfunction

	function automatic pq_beat_t make_scan(logic [63:0] lo, logic [63:0] hi, logic eol);
		pq_beat_t b;
		b.mode  = MODE_SCAN;
		b.row   = $urandom_range(0, 15);
		b.col   = $urandom_range(0, 255);
		b.value = entry_t'($urandom);
		b.lo    = lo;
		b.hi    = hi;
		b.eol   = eol;
		return b;
	endfunction

	// nearest written column from a random start
	function automatic logic [CODE_BITS-1:0] pick_code(int row);
		int start;
		int i;
		int c;
		start = $urandom_range(0, NUM_CENTROIDS - 1);
		for (i = 0; i < NUM_CENTROIDS; i++) begin
			c = (start + i) % NUM_CENTROIDS;
			if (entry_written[row][c])
				return c[CODE_BITS-1:0];
		end
		return start[CODE_BITS-1:0];
	endfunction

	function automatic entry_t pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return entry_t'($urandom);
		endcase
	endfunction

	task automatic send_beat(pq_beat_t b);
		logic [IN_TDATA_BITS-1:0] word;
		int                       gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
		end
		word = '0;
		word[SUB_LSB   +: SUB_FIELD_BITS]   = b.row;
		word[CENT_LSB  +: CENT_FIELD_BITS]  = b.col;
		word[VALUE_LSB +: VALUE_FIELD_BITS] = b.value;
		word[LO_LSB    +: CODES_WORD_BITS]  = b.lo;
		word[HI_LSB    +: CODES_WORD_BITS]  = b.hi;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= b.mode;
		s_axis_tlast  <= b.eol;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		record_beat(b);
		burst_left--;
	endtask

	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_distances.size() != 0) @(posedge clk);
	endtask

	task automatic test_corner_sums();
		int m;
		for (m = 0; m < NUM_SUBSPACES; m++)
			send_beat(make_write(m, 8'hFF, '1));
		// every lane at its largest entry
		send_beat(make_scan('1, '1, 1'b1));
		send_beat(make_write(0, 8'h00, '0));
		send_beat(make_scan(64'hFFFF_FFFF_FFFF_FF00, '1, 1'b0));
		send_beat(make_write(15, 8'hFF, '0));
		send_beat(make_write(7, 8'hFF, 24'h000001));
		send_beat(make_scan('1, '1, 1'b0));
		// write directly followed by a scan that reads it
		send_beat(make_write(8, 8'hFF, 24'h800000));
		send_beat(make_scan('1, '1, 1'b1));
	endtask

	task automatic test_fill_table();
		int m;
		for (m = 0; m < NUM_SUBSPACES; m++) begin
			send_beat(make_write(m, 8'h00, pick_value()));
			send_beat(make_write(m, 8'hFF, pick_value()));
			send_beat(make_write(m, $urandom_range(1, 254), pick_value()));
			send_beat(make_write(m, $urandom_range(1, 254), pick_value()));
		end
	endtask

	task automatic test_random_mix();
		int          i;
		int          m;
		int          flavour;
		logic [63:0] lo;
		logic [63:0] hi;
		for (i = 0; i < RANDOM_BEATS; i++) begin
			if (i == RANDOM_BEATS / 2)
				hold_until_drained();
			if ($urandom_range(0, 3) == 0) begin
				send_beat(make_write($urandom_range(0, 15), $urandom_range(0, 255), pick_value()));
			end else begin
				flavour = $urandom_range(0, 9);
				for (m = 0; m < NUM_SUBSPACES; m++) begin
					if (m < 8)
						lo[m*8 +: 8] = (flavour == 0) ? 8'hFF : (flavour == 1) ? 8'h00 : pick_code(m);
					else
						hi[(m-8)*8 +: 8] = (flavour == 0) ? 8'hFF : (flavour == 1) ? 8'h00 : pick_code(m);
				end
				send_beat(make_scan(lo, hi, $urandom_range(0, 7) == 0));
			end
		end
	endtask

	always @(posedge clk) begin
		if (pattern_left == 0) begin
			rx_pattern   <= rx_pattern_t'($urandom_range(0, 2));
			pattern_left <= $urandom_range(32, 160);
		end else begin
			pattern_left <= pattern_left - 1;
		end
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else begin
			case (rx_pattern)
				RX_STREAM: m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
				default: begin
					m_axis_tready <= 1'b1;
					if ($urandom_range(0, 5) == 0)
						stall_left <= $urandom_range(1, 16);
				end
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		distance_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_distances.size() == 0) begin
				$error("distance beat with no scan outstanding: distance %0d",
					m_axis_tdata[DIST_BITS-1:0]);
				fail_count++;
			end else begin
				want = pending_distances.pop_front();
				if (m_axis_tdata[DIST_BITS-1:0] !== want.distance) begin
					$error("distance: expected %0d, got %0d", want.distance,
						m_axis_tdata[DIST_BITS-1:0]);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last_result: expected %0d, got %0d", want.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_sums();
		test_fill_table();
		test_random_mix();
		hold_until_drained();
		repeat (DRAIN_SLACK) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
